>>> hdl/rttp_pkg.sv
// types, codes and palette constants for the terminal palette converter
`default_nettype none
package rttp_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] palette_index;
    } in_t;

    typedef struct packed {
        logic [1:0] form;
        logic [7:0] color_index;
    } out_t;

    localparam logic MODE_RGB   = 1'b0;
    localparam logic MODE_INDEX = 1'b1;

    localparam logic [1:0] FORM_RGB    = 2'd0;
    localparam logic [1:0] FORM_PAL256 = 2'd1;
    localparam logic [1:0] FORM_PAL16  = 2'd2;

    localparam logic [1:0] DEPTH_16   = 2'd0;
    localparam logic [1:0] DEPTH_256  = 2'd1;
    localparam logic [1:0] DEPTH_TRUE = 2'd2;

    localparam logic [7:0] CUBE_BASE  = 8'd16;
    localparam logic [7:0] GREY_BASE  = 8'd232;
    localparam logic [7:0] GREY_STEP  = 8'd10;
    localparam logic [2:0] CUBE_TOP   = 3'd5;
    localparam logic [2:0] ALL_CHANNELS = 3'd7;

    // named colors as {r, g, b}
    function automatic logic [23:0] named_rgb(input logic [3:0] i);
        logic [23:0] v;
        unique case (i)
            4'd0:  v = {8'd0,   8'd0,   8'd0};
            4'd1:  v = {8'd255, 8'd0,   8'd0};
            4'd2:  v = {8'd0,   8'd255, 8'd0};
            4'd3:  v = {8'd255, 8'd255, 8'd0};
            4'd4:  v = {8'd0,   8'd0,   8'd255};
            4'd5:  v = {8'd255, 8'd0,   8'd255};
            4'd6:  v = {8'd0,   8'd255, 8'd255};
            4'd7:  v = {8'd192, 8'd192, 8'd192};
            4'd8:  v = {8'd96,  8'd96,  8'd96};
            4'd9:  v = {8'd255, 8'd128, 8'd128};
            4'd10: v = {8'd128, 8'd255, 8'd128};
            4'd11: v = {8'd255, 8'd255, 8'd128};
            4'd12: v = {8'd128, 8'd128, 8'd255};
            4'd13: v = {8'd255, 8'd128, 8'd255};
            4'd14: v = {8'd128, 8'd255, 8'd255};
            default: v = {8'd255, 8'd255, 8'd255};
        endcase
        return v;
    endfunction

    // cube level times 42
    function automatic logic [7:0] cube_value(input logic [2:0] lvl);
        logic [7:0] v;
        unique case (lvl)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd42;
            3'd2:    v = 8'd84;
            3'd3:    v = 8'd126;
            3'd4:    v = 8'd168;
            3'd5:    v = 8'd210;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage
`default_nettype wire

>>> hdl/rgb_to_terminal_palette.sv
// terminal palette converter: nearest 256-color search and sixteen-color reduction
// truecolor pass-through and palette index at 256 or truecolor depth: valid in the cycle after the input is taken
// rgb below truecolor: search over all 256 palette entries, one palette entry per cycle, then result
// sixteen-color reduction then adds two digit steps and the mask map before the result
// one item at a time: s_ready returns the cycle after the result is taken
// synchronous active-low reset; the depth register resets to truecolor
`default_nettype none
module rgb_to_terminal_palette (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rttp_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rttp_pkg::out_t     m_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [1:0]    cfg_wr_data
);
    import rttp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV1,
        ST_DIV2,
        ST_MAP,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic [1:0]  depth_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [7:0]  cnt_reg;
    logic [2:0]  cr_reg, cg_reg, cb_reg;
    logic [7:0]  grey_reg;
    logic [9:0]  best_reg;
    logic [7:0]  idx_reg;
    out_t        out_reg;
    logic [2:0]  lr_reg, lg_reg, lb_reg;
    logic [5:0]  rem_reg;
    logic [1:0]  gsel_reg;

    logic        is_true;
    logic [23:0] named;
    logic [7:0]  er, eg, eb;
    logic [9:0]  entry_dist;
    logic        better;
    logic [7:0]  best_idx;
    logic [7:0]  cube_off;
    logic [13:0] r_prod;
    logic [2:0]  r_lvl;
    logic [7:0]  r_mul36;
    logic [4:0]  grey_off;
    logic [11:0] gsel_prod;
    logic [11:0] g_prod;
    logic [2:0]  g_lvl;
    logic [5:0]  g_mul6;
    logic [2:0]  mask0, mask1, top;
    logic [7:0]  map_idx;

    assign is_true = (depth_reg != DEPTH_16) && (depth_reg != DEPTH_256);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = out_reg;

    // palette entry at the current search position
    always_comb begin
        named = named_rgb(cnt_reg[3:0]);
        if (cnt_reg < CUBE_BASE) begin
            er = named[23:16];
            eg = named[15:8];
            eb = named[7:0];
        end else if (cnt_reg < GREY_BASE) begin
            er = cube_value(cr_reg);
            eg = cube_value(cg_reg);
            eb = cube_value(cb_reg);
        end else begin
            er = grey_reg;
            eg = grey_reg;
            eb = grey_reg;
        end
        entry_dist = {2'b00, abs_diff(red_reg, er)} + {2'b00, abs_diff(green_reg, eg)}
                   + {2'b00, abs_diff(blue_reg, eb)};
        better   = (entry_dist < best_reg);
        best_idx = better ? cnt_reg : idx_reg;
    end

    // digit split by reciprocal multiplication
    always_comb begin
        cube_off  = idx_reg - CUBE_BASE;
        r_prod    = {6'd0, cube_off} * 14'd57;
        r_lvl     = r_prod[13:11];
        r_mul36   = {5'd0, r_lvl} * 8'd36;
        grey_off  = 5'(idx_reg - GREY_BASE);
        gsel_prod = {7'd0, grey_off} * 12'd43;
        g_prod    = {6'd0, rem_reg} * 12'd43;
        g_lvl     = g_prod[10:8];
        g_mul6    = {3'd0, g_lvl} * 6'd6;
    end

    // dominant-channel rule
    always_comb begin
        priority if (lr_reg > lg_reg && lr_reg > lb_reg) begin
            mask0 = 3'd1;
            top   = lr_reg;
        end else if (lg_reg > lr_reg && lg_reg > lb_reg) begin
            mask0 = 3'd2;
            top   = lg_reg;
        end else if (lb_reg > lr_reg && lb_reg > lg_reg) begin
            mask0 = 3'd4;
            top   = lb_reg;
        end else begin
            mask0 = ALL_CHANNELS;
            top   = lr_reg;
        end
        priority if (lr_reg > (top >> 1)) begin
            mask1 = mask0 | 3'd1;
        end else if (lg_reg > (top >> 1)) begin
            mask1 = mask0 | 3'd2;
        end else if (lb_reg > (top >> 1)) begin
            mask1 = mask0 | 3'd4;
        end else begin
            mask1 = mask0;
        end
        priority if (idx_reg < CUBE_BASE) begin
            map_idx = idx_reg;
        end else if (idx_reg >= GREY_BASE) begin
            unique case (gsel_reg)
                2'd0:    map_idx = 8'd0;
                2'd1:    map_idx = 8'd8;
                2'd2:    map_idx = 8'd7;
                default: map_idx = 8'd15;
            endcase
        end else if (mask1 == ALL_CHANNELS) begin
            priority if (top == 3'd0) begin
                map_idx = 8'd0;
            end else if (top <= 3'd2) begin
                map_idx = 8'd8;
            end else if (top <= 3'd4) begin
                map_idx = 8'd7;
            end else begin
                map_idx = 8'd15;
            end
        end else begin
            map_idx = {5'd0, mask1} + ((top >= 3'd3) ? 8'd8 : 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            depth_reg <= DEPTH_TRUE;
        end else begin
            if (cfg_wr_en) begin
                depth_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        red_reg   <= s_data.red;
                        green_reg <= s_data.green;
                        blue_reg  <= s_data.blue;
                        cnt_reg   <= 8'd0;
                        cr_reg    <= 3'd0;
                        cg_reg    <= 3'd0;
                        cb_reg    <= 3'd0;
                        grey_reg  <= 8'd0;
                        best_reg  <= '1;
                        if (s_data.mode == MODE_RGB) begin
                            idx_reg <= 8'd0;
                            if (is_true) begin
                                out_reg.form        <= FORM_RGB;
                                out_reg.color_index <= 8'd0;
                                state_reg           <= ST_OUT;
                            end else begin
                                state_reg <= ST_SEARCH;
                            end
                        end else begin
                            idx_reg <= s_data.palette_index;
                            if (depth_reg != DEPTH_16) begin
                                out_reg.form        <= FORM_PAL256;
                                out_reg.color_index <= s_data.palette_index;
                                state_reg           <= ST_OUT;
                            end else begin
                                state_reg <= ST_DIV1;
                            end
                        end
                    end
                end
                ST_SEARCH: begin
                    if (better) begin
                        best_reg <= entry_dist;
                    end
                    idx_reg <= best_idx;
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg >= CUBE_BASE && cnt_reg < GREY_BASE) begin
                        if (cb_reg == CUBE_TOP) begin
                            cb_reg <= 3'd0;
                            if (cg_reg == CUBE_TOP) begin
                                cg_reg <= 3'd0;
                                cr_reg <= cr_reg + 3'd1;
                            end else begin
                                cg_reg <= cg_reg + 3'd1;
                            end
                        end else begin
                            cb_reg <= cb_reg + 3'd1;
                        end
                    end
                    if (cnt_reg >= GREY_BASE) begin
                        grey_reg <= grey_reg + GREY_STEP;
                    end
                    if (cnt_reg == 8'hFF) begin
                        if (depth_reg != DEPTH_16) begin
                            out_reg.form        <= FORM_PAL256;
                            out_reg.color_index <= best_idx;
                            state_reg           <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV1;
                        end
                    end
                end
                ST_DIV1: begin
                    lr_reg    <= r_lvl;
                    rem_reg   <= 6'(cube_off - r_mul36);
                    gsel_reg  <= gsel_prod[9:8];
                    state_reg <= ST_DIV2;
                end
                ST_DIV2: begin
                    lg_reg    <= g_lvl;
                    lb_reg    <= 3'(rem_reg - g_mul6);
                    state_reg <= ST_MAP;
                end
                ST_MAP: begin
                    out_reg.form        <= FORM_PAL16;
                    out_reg.color_index <= map_idx;
                    state_reg           <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_true_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_RGB && is_true)
        |=> (m_valid && m_data.form == FORM_RGB))
        else $error("truecolor item not passed through");

    a_rgb_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.form == FORM_RGB) |-> (m_data.color_index == 8'd0))
        else $error("rgb result with nonzero index");

    a_pal16_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.form == FORM_PAL16) |-> (m_data.color_index < 8'd16))
        else $error("sixteen-color index out of range");

    a_search_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && cnt_reg == 8'hFF) |=> (state_reg != ST_SEARCH))
        else $error("search ran past last palette entry");

endmodule
`default_nettype wire
